>>> rtl/fpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpt_pkg
// Shared widths, constants and types of the frame phase tracker.
// ----------------------------------------------------------------------------
package fpt_pkg;

	localparam int PERIOD_W   = 20;
	localparam int DEN_W      = 21;
	localparam int LIM_PROD_W = 29;
	localparam int LIMIT_W    = 27;

	localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = 20'd16667;
	localparam logic [PERIOD_W-1:0] MIN_PERIOD     = 20'd1000;
	localparam logic [PERIOD_W-1:0] MAX_PERIOD     = 20'd1000000;

	localparam logic [21:0] OFFSET_LIMIT   = 22'd2000000;
	localparam logic [13:0] REANCHOR_SCALE = 14'd10000;
	localparam logic [20:0] PHASE_ERR_MAX  = 21'd500000;

	// floor(x / 1000) as (x * PERMILLE_RECIP) >> PERMILLE_SHIFT, exact for x below 2^29
	localparam logic [29:0] PERMILLE_RECIP = 30'd549755814;
	localparam int          PERMILLE_SHIFT = 39;

	localparam logic [21:0] RST_STALL_FLOOR = 22'd250000;
	localparam logic [6:0]  RST_STALL_MULT  = 7'd8;
	localparam logic [3:0]  RST_CORR_SHIFT  = 4'd4;
	localparam logic [8:0]  RST_CORR_LIMIT  = 9'd30;

	typedef enum logic [1:0] {
		CFG_STALL_FLOOR = 2'd0,
		CFG_STALL_MULT  = 2'd1,
		CFG_CORR_SHIFT  = 2'd2,
		CFG_CORR_LIMIT  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> rtl/frame_phase_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_phase_tracker
// Display refresh phase tracker: anchoring, stall checks, missed-period
// catch-up on queries and error-corrected target advance on swaps.
// ----------------------------------------------------------------------------
// One item at a time. A query ends with S_OFF and S_SAT, after the divider and
// S_ADD1 if it catches up; an accepted swap runs the divider, S_LDIV, S_CORR, S_ADD1
// and S_ADD2; a rejected swap goes straight to S_OUT. The shared restoring divider
// takes TIME_BITS + 1 steps, one bit per cycle, for the missed periods. The next
// item is taken the cycle after the result is loaded, so a stalled result holds the
// block. Reset clears all tracking state and loads the register defaults.
module frame_phase_tracker
	import fpt_pkg::*;
#(
	parameter int TIME_BITS = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [21:0]                 cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        func,
	input  logic [TIME_BITS-1:0]        time_us,
	input  logic [23:0]                 refresh_us,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [21:0]          offset_us,
	output logic signed [20:0]          phase_error_us,
	output logic                        swap_accepted,
	output logic                        reanchored
);

	localparam int NUM_W     = TIME_BITS + 1;
	localparam int SUM_W     = TIME_BITS + 2;
	localparam int IDX_W     = $clog2(NUM_W);
	localparam int LIM_MUL_W = LIM_PROD_W + 30;
	localparam logic signed [TIME_BITS-1:0] OFF_HI = TIME_BITS'(OFFSET_LIMIT);
	localparam logic signed [TIME_BITS-1:0] OFF_LO = -OFF_HI;
	localparam logic [21:0] OFF_NEG = ~OFFSET_LIMIT + 22'd1;

	typedef enum logic [4:0] {
		S_IDLE, S_LIM, S_TST0, S_TST1, S_TST2, S_DIFF, S_SEL, S_DSTART, S_DIV,
		S_LDIV, S_CORR, S_ADD1, S_ADD2, S_OFF, S_SAT, S_OUT
	} state_t;

	// configuration registers
	logic [21:0] stall_floor_q;
	logic [6:0]  stall_mult_q;
	logic [3:0]  corr_shift_q;
	logic [8:0]  corr_limit_q;

	// tracking state
	logic                  started_q;
	logic                  armed_q;
	logic [PERIOD_W-1:0]   period_q;
	logic [TIME_BITS-1:0]  target_q;
	logic [TIME_BITS-1:0]  last_q;
	logic [20:0]           phase_err_q;

	// per-item working registers
	state_t                state_q;
	logic                  func_q;
	logic [TIME_BITS-1:0]  now_q;
	logic [PERIOD_W-1:0]   p_q;
	logic [LIMIT_W-1:0]    lraw_q;
	logic [LIMIT_W-1:0]    limit_q;
	logic [PERIOD_W-1:0]   dp_q;
	logic [33:0]           dpx_q;
	logic                  bad_q;
	logic                  re_q;
	logic                  acc_q;
	logic [TIME_BITS-1:0]  d_q;
	logic [NUM_W-1:0]      num_q;
	logic [LIM_PROD_W-1:0] lprod_q;
	logic [TIME_BITS-1:0]  mp_q;
	logic [20:0]           err_q;
	logic [PERIOD_W-1:0]   lim_q;
	logic [20:0]           corr_q;
	logic [TIME_BITS-1:0]  off_q;
	logic [21:0]           offs_q;

	// output register
	logic                  out_valid_q;
	logic [21:0]           offset_out_q;
	logic [20:0]           phase_out_q;
	logic                  acc_out_q;
	logic                  re_out_q;

	// divider connection
	logic                  div_start;
	logic [NUM_W-1:0]      div_num;
	logic [DEN_W-1:0]      div_den;
	logic [IDX_W-1:0]      div_msb;
	logic [DEN_W-1:0]      div_rem;
	div_stat_t             div_stat;

	// combinational helpers
	logic [PERIOD_W-1:0]   p_in;
	logic [SUM_W-1:0]      two_d;
	logic [SUM_W-1:0]      per_w;
	logic [SUM_W-1:0]      num_s;
	logic [SUM_W-1:0]      t_s;
	logic [NUM_W-1:0]      mp_full;
	logic [21:0]           e_full;
	logic [LIM_MUL_W-1:0]  lim_full;
	logic signed [20:0]    sh;
	logic signed [21:0]    sh_w;
	logic signed [21:0]    lim_w;
	logic [20:0]           corr_c;
	logic                  out_free;

	function automatic logic beyond(input logic [TIME_BITS-1:0] a,
			input logic [TIME_BITS-1:0] b, input logic [LIMIT_W-1:0] lim);
		logic [TIME_BITS-1:0] dd;
		dd = a - b;
		return $signed(dd) > $signed(TIME_BITS'(lim));
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_floor_q <= RST_STALL_FLOOR;
			stall_mult_q  <= RST_STALL_MULT;
			corr_shift_q  <= RST_CORR_SHIFT;
			corr_limit_q  <= RST_CORR_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_STALL_FLOOR: stall_floor_q <= cfg_data;
				CFG_STALL_MULT:  stall_mult_q  <= cfg_data[6:0];
				CFG_CORR_SHIFT:  corr_shift_q  <= cfg_data[3:0];
				CFG_CORR_LIMIT:  corr_limit_q  <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (refresh_us == 24'd0)
			p_in = DEFAULT_PERIOD;
		else if (refresh_us < {4'b0, MIN_PERIOD})
			p_in = MIN_PERIOD;
		else if (refresh_us > {4'b0, MAX_PERIOD})
			p_in = MAX_PERIOD;
		else
			p_in = refresh_us[PERIOD_W-1:0];

		two_d = {d_q[TIME_BITS-1], d_q, 1'b0};
		per_w = SUM_W'(period_q);
		num_s = two_d + per_w;
		t_s   = two_d - per_w;

		// remainder r of (2d + per) / 2per gives missed * per and the error
		mp_full = num_q - NUM_W'(div_rem);
		e_full  = {1'b0, div_rem} - {2'b00, period_q};

		// correction limit, period * permille / 1000 by reciprocal
		lim_full = {30'b0, lprod_q} * {29'b0, PERMILLE_RECIP};

		sh    = $signed(err_q) >>> corr_shift_q;
		sh_w  = {sh[20], sh};
		lim_w = {2'b00, lim_q};
		if (sh_w > lim_w)
			corr_c = {1'b0, lim_q};
		else if (sh_w < -lim_w)
			corr_c = ~{1'b0, lim_q} + 21'd1;
		else
			corr_c = sh;

		div_start = (state_q == S_DSTART);
		div_num   = num_q;
		div_den   = {period_q, 1'b0};
		div_msb   = IDX_W'(NUM_W - 1);

		out_free = !out_valid_q || !out_stall;
	end

	fpt_div #(
		.NUM_W (NUM_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_num),
		.divisor   (div_den),
		.msb       (div_msb),
		.remainder (div_rem),
		.stat      (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			started_q    <= 1'b0;
			armed_q      <= 1'b0;
			period_q     <= '0;
			target_q     <= '0;
			last_q       <= '0;
			phase_err_q  <= '0;
			func_q       <= 1'b0;
			now_q        <= '0;
			p_q          <= '0;
			lraw_q       <= '0;
			limit_q      <= '0;
			dp_q         <= '0;
			dpx_q        <= '0;
			bad_q        <= 1'b0;
			re_q         <= 1'b0;
			acc_q        <= 1'b0;
			d_q          <= '0;
			num_q        <= '0;
			lprod_q      <= '0;
			mp_q         <= '0;
			err_q        <= '0;
			lim_q        <= '0;
			corr_q       <= '0;
			off_q        <= '0;
			offs_q       <= '0;
			out_valid_q  <= 1'b0;
			offset_out_q <= '0;
			phase_out_q  <= '0;
			acc_out_q    <= 1'b0;
			re_out_q     <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_OUT)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						func_q  <= func;
						now_q   <= time_us;
						p_q     <= p_in;
						offs_q  <= '0;
						acc_q   <= 1'b0;
						state_q <= S_LIM;
					end
				end
				S_LIM: begin
					lraw_q  <= {7'b0, p_q} * {20'b0, stall_mult_q};
					dp_q    <= (p_q >= period_q) ? p_q - period_q : period_q - p_q;
					state_q <= S_TST0;
				end
				S_TST0: begin
					limit_q <= (lraw_q < LIMIT_W'(stall_floor_q)) ?
						LIMIT_W'(stall_floor_q) : lraw_q;
					dpx_q   <= {14'b0, dp_q} * {20'b0, REANCHOR_SCALE};
					state_q <= S_TST1;
				end
				S_TST1: begin
					bad_q   <= (dpx_q > {14'b0, p_q}) || beyond(now_q, last_q, limit_q);
					state_q <= S_TST2;
				end
				S_TST2: begin
					started_q <= 1'b1;
					period_q  <= p_q;
					last_q    <= now_q;
					if (!started_q || bad_q || beyond(now_q, target_q, limit_q)) begin
						target_q    <= now_q + TIME_BITS'(p_q);
						phase_err_q <= '0;
						armed_q     <= 1'b0;
						re_q        <= 1'b1;
					end else begin
						re_q <= 1'b0;
					end
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					d_q     <= now_q - target_q;
					state_q <= S_SEL;
				end
				S_SEL: begin
					num_q   <= num_s[NUM_W-1:0];
					lprod_q <= {9'b0, period_q} * {20'b0, corr_limit_q};
					if (!func_q) begin
						armed_q <= 1'b1;
						// catch up only when at least half a period late
						state_q <= t_s[SUM_W-1] ? S_OFF : S_DSTART;
					end else begin
						state_q <= (armed_q && !num_s[SUM_W-1]) ? S_DSTART : S_OUT;
					end
				end
				S_DSTART: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						mp_q    <= mp_full[NUM_W-1:1];
						err_q   <= e_full[21:1];
						state_q <= func_q ? S_LDIV : S_ADD1;
					end
				end
				S_LDIV: begin
					lim_q   <= lim_full[PERMILLE_SHIFT +: PERIOD_W];
					state_q <= S_CORR;
				end
				S_CORR: begin
					corr_q      <= corr_c;
					phase_err_q <= err_q;
					state_q     <= S_ADD1;
				end
				S_ADD1: begin
					target_q <= target_q + mp_q;
					state_q  <= func_q ? S_ADD2 : S_OFF;
				end
				S_ADD2: begin
					target_q <= target_q + TIME_BITS'(period_q) +
						{{(TIME_BITS-21){corr_q[20]}}, corr_q};
					armed_q  <= 1'b0;
					acc_q    <= 1'b1;
					state_q  <= S_OUT;
				end
				S_OFF: begin
					off_q   <= target_q - now_q;
					state_q <= S_SAT;
				end
				S_SAT: begin
					if ($signed(off_q) > OFF_HI)
						offs_q <= OFFSET_LIMIT;
					else if ($signed(off_q) < OFF_LO)
						offs_q <= OFF_NEG;
					else
						offs_q <= off_q[21:0];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						offset_out_q <= offs_q;
						phase_out_q  <= phase_err_q;
						acc_out_q    <= acc_q;
						re_out_q     <= re_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall       = (state_q != S_IDLE);
	assign out_valid      = out_valid_q;
	assign offset_us      = offset_out_q;
	assign phase_error_us = phase_out_q;
	assign swap_accepted  = acc_out_q;
	assign reanchored     = re_out_q;

	a_item_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while one is in progress");

	a_swap_no_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && swap_accepted |-> offset_us == 22'sd0)
		else $error("accepted swap carries an offset");

	a_anchor_no_swap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reanchored |-> !swap_accepted)
		else $error("swap accepted on a re-anchoring item");

	a_err_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> phase_error_us <= $signed(PHASE_ERR_MAX) &&
			phase_error_us >= -$signed(PHASE_ERR_MAX))
		else $error("phase error beyond half the longest period");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider restarted while busy");

endmodule

>>> rtl/fpt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpt_div
// Restoring remainder unit, one dividend bit per cycle from a chosen top bit
// down.
// ----------------------------------------------------------------------------
module fpt_div
	import fpt_pkg::*;
#(
	parameter int NUM_W = 49
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [NUM_W-1:0]           dividend,
	input  logic [DEN_W-1:0]           divisor,
	input  logic [$clog2(NUM_W)-1:0]   msb,
	output logic [DEN_W-1:0]           remainder,
	output div_stat_t                  stat
);

	localparam int IDX_W = $clog2(NUM_W);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [IDX_W-1:0] idx_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   part;
	logic [DEN_W+1:0] trial;
	logic             fits;

	always_comb begin
		part  = {rem_q, num_q[idx_q]};
		trial = {1'b0, part} - {2'b00, den_q};
		fits  = !trial[DEN_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			idx_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (start) begin
				num_q  <= dividend;
				den_q  <= divisor;
				rem_q  <= '0;
				idx_q  <= msb;
				busy_q <= 1'b1;
				done_q <= 1'b0;
			end else if (busy_q) begin
				// partial remainder stays below the divisor
				rem_q <= fits ? trial[DEN_W-1:0] : part[DEN_W-1:0];
				if (idx_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					idx_q  <= idx_q - 1'b1;
					done_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	assign remainder = rem_q;
	assign stat      = '{busy: busy_q, done: done_q};

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

	a_last_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !start && idx_q == '0 |=> done_q && !busy_q)
		else $error("divider did not finish after its last step");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < den_q)
		else $error("remainder not below divisor");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for frame_phase_tracker. Query and swap items go in
// with random gaps while the result side stalls at random. An in-bench
// tracker predicts offset, phase error and flags for every item, and each
// result is checked against the oldest prediction. Edge cases run first,
// then random frame sessions under several register settings.
// ----------------------------------------------------------------------------
module testbench
	import fpt_pkg::*;
();

	localparam int TB_TIME_BITS   = 48;
	localparam int SETTLE_CYCLES  = 160;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef enum logic {
		OP_QUERY = 1'b0,
		OP_SWAP  = 1'b1
	} frame_op_t;

	typedef struct packed {
		logic signed [21:0] offset_us;
		logic signed [20:0] phase_error_us;
		logic               swap_accepted;
		logic               reanchored;
	} frame_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [1:0]                cfg_index;
	logic [21:0]               cfg_data;
	logic                      in_valid;
	logic                      in_stall;
	logic                      func;
	logic [TB_TIME_BITS-1:0]   time_us;
	logic [23:0]               refresh_us;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [21:0]        offset_us;
	logic signed [20:0]        phase_error_us;
	logic                      swap_accepted;
	logic                      reanchored;

	// tracker state and register copies
	logic                      trk_started;
	logic                      trk_armed;
	logic [19:0]               trk_period;
	logic [TB_TIME_BITS-1:0]   trk_target;
	logic [TB_TIME_BITS-1:0]   trk_last_seen;
	logic signed [20:0]        trk_phase_err;
	logic [21:0]               floor_us_reg;
	logic [6:0]                stall_mult_reg;
	logic [3:0]                corr_shift_reg;
	logic [8:0]                corr_permille_reg;

	frame_result_t             expected_frames[$];
	logic [TB_TIME_BITS-1:0]   last_time;
	bit                        sender_steady;
	bit                        sink_steady;
	int                        mismatch_count;
	int                        quiet_cycles;
	int                        stall_left;

	frame_phase_tracker #(.TIME_BITS(TB_TIME_BITS)) dut (.*);

	always #5 clk = ~clk;

	function automatic longint time_diff(input logic [TB_TIME_BITS-1:0] a,
			input logic [TB_TIME_BITS-1:0] b);
		logic [TB_TIME_BITS-1:0] u;
		u = a - b;
		return {{(64-TB_TIME_BITS){u[TB_TIME_BITS-1]}}, u};
	endfunction

	function automatic logic [TB_TIME_BITS-1:0] time_add(input logic [TB_TIME_BITS-1:0] t,
			input longint delta);
		logic [63:0] dv;
		dv = delta;
		return t + dv[TB_TIME_BITS-1:0];
	endfunction

	function automatic void anchor_target(input logic [TB_TIME_BITS-1:0] now,
			input logic [19:0] p);
		trk_period    = p;
		trk_target    = time_add(now, longint'(p));
		trk_last_seen = now;
		trk_phase_err = '0;
		trk_armed     = 1'b0;
	endfunction

	function automatic frame_result_t track_frame_phase(input frame_op_t op,
			input logic [TB_TIME_BITS-1:0] now, input logic [23:0] refresh);
		logic [19:0]   p;
		longint        stall_lim, drift, per, d, missed, err, lim, corr, offs;
		frame_result_t res;
		res  = '0;
		offs = 0;
		if (refresh == 0)
			p = DEFAULT_PERIOD;
		else if (refresh < MIN_PERIOD)
			p = MIN_PERIOD;
		else if (refresh > MAX_PERIOD)
			p = MAX_PERIOD;
		else
			p = refresh[19:0];

		if (!trk_started) begin
			trk_started = 1'b1;
			anchor_target(now, p);
			res.reanchored = 1'b1;
		end else begin
			stall_lim = longint'(p) * longint'(stall_mult_reg);
			if (stall_lim < longint'(floor_us_reg))
				stall_lim = longint'(floor_us_reg);
			drift = longint'(p) - longint'(trk_period);
			if (drift < 0)
				drift = -drift;
			if (drift * 10000 > longint'(p) || time_diff(now, trk_last_seen) > stall_lim ||
					time_diff(now, trk_target) > stall_lim) begin
				anchor_target(now, p);
				res.reanchored = 1'b1;
			end else begin
				trk_period    = p;
				trk_last_seen = now;
			end
		end

		per = longint'(trk_period);
		d   = time_diff(now, trk_target);
		if (op == OP_QUERY) begin
			// roll missed frames forward, rounding to the nearest one
			if (d >= 0 && 2 * d >= per) begin
				missed     = (2 * d + per) / (2 * per);
				trk_target = time_add(trk_target, missed * per);
			end
			trk_armed = 1'b1;
			offs = time_diff(trk_target, now);
			if (offs > longint'(OFFSET_LIMIT))
				offs = longint'(OFFSET_LIMIT);
			if (offs < -longint'(OFFSET_LIMIT))
				offs = -longint'(OFFSET_LIMIT);
		end else if (trk_armed && d >= -per && 2 * d >= -per) begin
			missed = (2 * d + per) / (2 * per);
			err    = d - missed * per;
			lim    = per * longint'(corr_permille_reg) / 1000;
			corr   = err >>> corr_shift_reg;
			if (corr > lim)
				corr = lim;
			if (corr < -lim)
				corr = -lim;
			trk_phase_err = 21'(err);
			trk_target    = time_add(trk_target, missed * per + per + corr);
			trk_armed     = 1'b0;
			res.swap_accepted = 1'b1;
		end
		res.offset_us      = 22'(offs);
		res.phase_error_us = trk_phase_err;
		return res;
	endfunction

	function automatic int pick_gap(input bit steady);
		int roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [23:0] pick_interval();
		case ($urandom_range(0, 7))
			0: return 24'd0;
			1: return 24'd16667;
			2: return 24'd8333;
			3: return 24'd6944;
			4: return 24'($urandom_range(1000, 20000));
			5: return 24'($urandom_range(1000, 1000000));
			6: return 24'd1000;
			default: return 24'd1000000;
		endcase
	endfunction

	// swap time relative to the current target
	function automatic longint swap_jitter(input longint per);
		case ($urandom_range(0, 9))
			7: return -per + longint'($urandom_range(0, int'(per / 2)));
			8: return per / 2 + longint'($urandom_range(0, int'(5 * per / 2)));
			9: begin
				case ($urandom_range(0, 3))
					0: return 0;
					1: return -(per / 2);
					2: return -((per + 1) / 2);
					default: return per / 2;
				endcase
			end
			default: return longint'($urandom_range(0, int'(per))) - per / 2;
		endcase
	endfunction

	task automatic send_item(input frame_op_t op, input logic [TB_TIME_BITS-1:0] t,
			input logic [23:0] refresh);
		int gap;
		gap = pick_gap(sender_steady);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		func       <= op;
		time_us    <= t;
		refresh_us <= refresh;
		in_valid   <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		expected_frames.push_back(track_frame_phase(op, t, refresh));
		last_time = t;
		@(negedge clk);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (expected_frames.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// leaves the write valid high so back-to-back writes need no toggle
	task automatic write_reg(input cfg_reg_t idx, input logic [21:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			CFG_STALL_FLOOR: floor_us_reg      = value;
			CFG_STALL_MULT:  stall_mult_reg    = value[6:0];
			CFG_CORR_SHIFT:  corr_shift_reg    = value[3:0];
			CFG_CORR_LIMIT:  corr_permille_reg = value[8:0];
		endcase
		@(negedge clk);
	endtask

	task automatic apply_config(input logic [21:0] floor_us, input logic [6:0] mult,
			input logic [3:0] shift, input logic [8:0] permille);
		wait_drain();
		write_reg(CFG_STALL_FLOOR, floor_us);
		write_reg(CFG_STALL_MULT, 22'(mult));
		write_reg(CFG_CORR_SHIFT, 22'(shift));
		write_reg(CFG_CORR_LIMIT, 22'(permille));
		cfg_valid <= 1'b0;
	endtask

	// mostly query then swap near the target, with some noise mixed in
	task automatic run_sessions(input int n_items);
		logic [23:0]             interval;
		logic [23:0]             refresh;
		logic [TB_TIME_BITS-1:0] t;
		frame_op_t               op;
		longint                  per;
		int                      k;
		int                      roll;
		interval = 24'd16667;
		for (k = 0; k < n_items; k++) begin
			if (k % 100 == 0) begin
				sender_steady = ($urandom_range(0, 3) == 0);
				sink_steady   = ($urandom_range(0, 3) == 0);
			end
			if (k == 0 || $urandom_range(0, 59) == 0)
				interval = pick_interval();
			per     = (trk_period == 0) ? 64'sd16667 : longint'(trk_period);
			refresh = interval;
			op      = OP_QUERY;
			t       = time_add(last_time, longint'($urandom_range(0, int'(per / 2))));
			roll    = $urandom_range(0, 99);
			if (roll < 80) begin
				if ($urandom_range(0, 19) == 0)
					refresh = interval + 24'd1;
				if (trk_armed ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0)) begin
					op = OP_SWAP;
					t  = time_add(trk_target, swap_jitter(per));
				end else if ($urandom_range(0, 9) == 0) begin
					t = time_add(last_time, longint'($urandom_range(int'(per), int'(5 * per))));
				end
			end else begin
				op = frame_op_t'($urandom_range(0, 1));
				case ($urandom_range(0, 5))
					0: t = time_add(last_time, -longint'($urandom_range(0, 5000000)));
					1: t = time_add(last_time, longint'($urandom_range(0, 140000000)));
					2: t = TB_TIME_BITS'({$urandom(), $urandom()});
					3: refresh = 24'($urandom());
					4: refresh = ($urandom_range(0, 1) == 0) ? 24'd0 : 24'($urandom_range(1, 999));
					default: t = time_add(trk_target,
						longint'($urandom_range(0, int'(6 * per))) - 3 * per);
				endcase
			end
			send_item(op, t, refresh);
		end
	endtask

	task automatic test_directed_edges();
		send_item(OP_SWAP, 48'd0, 24'd0);             // swap as first item, not armed
		send_item(OP_QUERY, 48'd5000, 24'd16667);
		send_item(OP_SWAP, trk_target, 24'd16667);     // right on target
		send_item(OP_QUERY, time_add(last_time, 2000), 24'd16667);
		send_item(OP_SWAP, time_add(trk_target, -12500), 24'd16667);  // far too early
		send_item(OP_SWAP, time_add(trk_target, 3000), 24'd16667);
		send_item(OP_SWAP, time_add(last_time, 16667), 24'd16667);    // no query since swap
		send_item(OP_QUERY, time_add(last_time, 100), 24'd16668);     // drift within tolerance
		send_item(OP_QUERY, time_add(last_time, 100), 24'd16670);     // drift beyond tolerance
		send_item(OP_QUERY, time_add(last_time, 50000), 24'd16670);
		send_item(OP_QUERY, time_add(last_time, 100), 24'd1);
		send_item(OP_QUERY, time_add(last_time, 100), 24'd999);
		send_item(OP_QUERY, time_add(last_time, 100), 24'd1000);
		send_item(OP_QUERY, time_add(last_time, 100), 24'd1000000);
		send_item(OP_QUERY, time_add(last_time, 100), 24'd1000001);
		send_item(OP_QUERY, time_add(last_time, 100), 24'hFFFFFF);
		// time runs backwards, offset saturates
		send_item(OP_QUERY, time_add(last_time, -3000000), 24'hFFFFFF);
		send_item(OP_QUERY, time_add(trk_target, 2400000), 24'd1000000);
		send_item(OP_SWAP, time_add(trk_target, 1700000), 24'd1000000);
		send_item(OP_QUERY, time_add(last_time, 9000000), 24'd1000000);  // stalled
		// target wraps past the top of the time range
		send_item(OP_QUERY, 48'hFFFF_FFFF_FF00, 24'd20000);
		send_item(OP_QUERY, time_add(last_time, 15000), 24'd20000);
		send_item(OP_SWAP, time_add(trk_target, 500), 24'd20000);
	endtask

	task automatic test_default_tracking();
		run_sessions(400);
	endtask

	task automatic test_stall_limits();
		apply_config(22'd0, 7'd0, 4'd4, 9'd30);
		run_sessions(250);
		apply_config(22'h3FFFFF, 7'd127, 4'd4, 9'd30);
		run_sessions(250);
		apply_config(22'd4000000, 7'd64, 4'd4, 9'd30);
		run_sessions(150);
	endtask

	task automatic test_correction_limits();
		apply_config(22'd250000, 7'd1, 4'd0, 9'd500);
		run_sessions(200);
		apply_config(22'd250000, 7'd8, 4'd15, 9'd0);
		run_sessions(200);
		apply_config(22'd100000, 7'd8, 4'd0, 9'd511);
		run_sessions(150);
		apply_config(RST_STALL_FLOOR, RST_STALL_MULT, RST_CORR_SHIFT, RST_CORR_LIMIT);
		run_sessions(100);
	endtask

	// result side back-pressure
	always @(negedge clk) begin
		int roll;
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (sink_steady) begin
			out_stall <= 1'b0;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b1;
				stall_left = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
			end
		end
	end

	always @(posedge clk) begin
		frame_result_t got;
		frame_result_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			got = {offset_us, phase_error_us, swap_accepted, reanchored};
			if (expected_frames.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected result: offset %0d phase %0d acc %0b re %0b",
						got.offset_us, got.phase_error_us, got.swap_accepted, got.reanchored);
				mismatch_count++;
			end else begin
				want = expected_frames.pop_front();
				if (got !== want) begin
					if (mismatch_count < 10)
						$display("mismatch: expected offset %0d phase %0d acc %0b re %0b, got offset %0d phase %0d acc %0b re %0b",
							want.offset_us, want.phase_error_us, want.swap_accepted,
							want.reanchored, got.offset_us, got.phase_error_us,
							got.swap_accepted, got.reanchored);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
				(cfg_valid && cfg_ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n            = 1'b0;
		cfg_valid         = 1'b0;
		cfg_index         = CFG_STALL_FLOOR;
		cfg_data          = '0;
		in_valid          = 1'b0;
		func              = OP_QUERY;
		time_us           = '0;
		refresh_us        = '0;
		out_stall         = 1'b0;
		stall_left        = 0;
		sender_steady     = 1'b0;
		sink_steady       = 1'b0;
		mismatch_count    = 0;
		quiet_cycles      = 0;
		last_time         = '0;
		trk_started       = 1'b0;
		trk_armed         = 1'b0;
		trk_period        = '0;
		trk_target        = '0;
		trk_last_seen     = '0;
		trk_phase_err     = '0;
		floor_us_reg      = RST_STALL_FLOOR;
		stall_mult_reg    = RST_STALL_MULT;
		corr_shift_reg    = RST_CORR_SHIFT;
		corr_permille_reg = RST_CORR_LIMIT;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_edges();
		test_default_tracking();
		test_stall_limits();
		test_correction_limits();
		wait_drain();

		if (mismatch_count == 0 && expected_frames.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
